FILE: sv/full_weighting_restriction_2d_macros.svh
// Assertion macros shared by the restriction block's RTL.
// Define ASSERT_OFF to compile the checks away; no other dependencies.
`ifndef FULL_WEIGHTING_RESTRICTION_2D_MACROS_SVH
`define FULL_WEIGHTING_RESTRICTION_2D_MACROS_SVH
`ifndef ASSERT_OFF
// expr must hold at every clock edge outside reset
`define FWR2D_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("fwr2d assertion failed");
// cons must hold in the same cycle as ante
`define FWR2D_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fwr2d implication failed");
// cons must hold in the cycle after ante
`define FWR2D_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwr2d next-cycle check failed");
`else
`define FWR2D_ASSERT(label, clk, rst_n, expr)
`define FWR2D_IMPLY(label, clk, rst_n, ante, cons)
`define FWR2D_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/fwr2d_pkg.sv
// Shared types and constants of the 2-D full-weighting restriction block.
// No dependencies; used by every module of the block.
package fwr2d_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int MAX_FINE_WIDTH = 1023;
    localparam int CFG_BITS       = 9;
    localparam int POS_BITS       = 10;
    localparam int SUM_BITS       = SAMPLE_BITS + 4;
    localparam int FIFO_DEPTH     = 3;
    localparam int CNT_BITS       = 2;

    localparam logic [0:0] CFG_IDX_COLS = 1'b0;
    localparam logic [0:0] CFG_IDX_ROWS = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // one line-store entry: the fine rows one and two above
    typedef struct packed {
        t_sample mid;
        t_sample up;
    } t_line_pair;

    // control of the item in the read-modify-write stage
    typedef struct packed {
        logic                valid;
        logic                emit;
        logic                last;
        logic                fwd;
        logic [POS_BITS-1:0] col;
    } t_s1_ctrl;

    typedef struct packed {
        t_sample value;
        logic    last;
    } t_result;

endpackage

FILE: sv/fwr2d_line_mem.sv
// Line store of the restriction block: both previous fine rows in one word.
// Synchronous memory, one write and one registered read port; uses fwr2d_pkg.
module fwr2d_line_mem (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [fwr2d_pkg::POS_BITS-1:0] i_rd_addr,
    output fwr2d_pkg::t_line_pair          o_rd_data,
    input  logic                          i_wr_en,
    input  logic [fwr2d_pkg::POS_BITS-1:0] i_wr_addr,
    input  fwr2d_pkg::t_line_pair          i_wr_data
);

    fwr2d_pkg::t_line_pair r_mem [0:fwr2d_pkg::MAX_FINE_WIDTH-1];
    fwr2d_pkg::t_line_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/fwr2d_window.sv
// 3x3 window registers and the 1-2-1 / 2-4-2 / 1-2-1 weighted sum.
// Fed by the read-modify-write stage of the top level; uses fwr2d_pkg.
module fwr2d_window (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fwr2d_pkg::t_s1_ctrl   i_ctrl,
    input  fwr2d_pkg::t_sample    i_up,
    input  fwr2d_pkg::t_sample    i_mid,
    input  fwr2d_pkg::t_sample    i_cur,
    output logic                  o_push,
    output fwr2d_pkg::t_result    o_result
);

    // two previous columns of each window row
    fwr2d_pkg::t_sample r_up1, r_up2, r_mid1, r_mid2, r_cur1, r_cur2;

    logic signed [fwr2d_pkg::SUM_BITS-1:0] corners;
    logic signed [fwr2d_pkg::SUM_BITS-1:0] edges;
    logic signed [fwr2d_pkg::SUM_BITS-1:0] sum;

    always_comb begin
        corners = fwr2d_pkg::SUM_BITS'(r_up2) + fwr2d_pkg::SUM_BITS'(i_up)
                + fwr2d_pkg::SUM_BITS'(r_cur2) + fwr2d_pkg::SUM_BITS'(i_cur);
        edges   = fwr2d_pkg::SUM_BITS'(r_up1) + fwr2d_pkg::SUM_BITS'(r_mid2)
                + fwr2d_pkg::SUM_BITS'(i_mid) + fwr2d_pkg::SUM_BITS'(r_cur1);
        sum     = corners + (edges <<< 1) + (fwr2d_pkg::SUM_BITS'(r_mid1) <<< 2);
    end

    // floor division by 16: drop the low four bits of the two's-complement sum
    assign o_result.value = sum[fwr2d_pkg::SUM_BITS-1:4];
    assign o_result.last  = i_ctrl.last;
    assign o_push         = i_ctrl.valid && i_ctrl.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up1  <= '0;
            r_up2  <= '0;
            r_mid1 <= '0;
            r_mid2 <= '0;
            r_cur1 <= '0;
            r_cur2 <= '0;
        end else if (i_ctrl.valid) begin
            r_up2  <= r_up1;
            r_up1  <= i_up;
            r_mid2 <= r_mid1;
            r_mid1 <= i_mid;
            r_cur2 <= r_cur1;
            r_cur1 <= i_cur;
        end
    end

endmodule

FILE: sv/fwr2d_out_fifo.sv
// Three-entry result queue that decouples the output side from the pipeline.
// Uses fwr2d_pkg and the block's assertion macros.
`include "full_weighting_restriction_2d_macros.svh"
module fwr2d_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  fwr2d_pkg::t_result            i_data,
    output logic                          o_valid,
    output fwr2d_pkg::t_result            o_data,
    input  logic                          i_ready,
    output logic [fwr2d_pkg::CNT_BITS-1:0] o_count
);

    fwr2d_pkg::t_result r_q [0:fwr2d_pkg::FIFO_DEPTH-1];
    logic [fwr2d_pkg::CNT_BITS-1:0] r_wr_ptr, r_rd_ptr, r_count;
    logic [fwr2d_pkg::CNT_BITS-1:0] n_wr_ptr, n_rd_ptr, n_count;
    logic pop;

    localparam logic [fwr2d_pkg::CNT_BITS-1:0] LAST_PTR =
        fwr2d_pkg::CNT_BITS'(fwr2d_pkg::FIFO_DEPTH - 1);
    localparam logic [fwr2d_pkg::CNT_BITS-1:0] FULL_CNT =
        fwr2d_pkg::CNT_BITS'(fwr2d_pkg::FIFO_DEPTH);

    assign o_valid = (r_count != '0);
    assign o_data  = r_q[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `FWR2D_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_CNT)
    `FWR2D_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push && !pop, r_count != FULL_CNT)
    `FWR2D_IMPLY(a_ptr_gap, i_clk, i_rst_n, r_count == '0 || r_count == FULL_CNT, r_wr_ptr == r_rd_ptr)

endmodule

FILE: sv/full_weighting_restriction_2d.sv
// Top level of the 2-D full-weighting restriction (3x3 multigrid stencil).
// Uses fwr2d_pkg, fwr2d_line_mem, fwr2d_window, fwr2d_out_fifo and the macros.
//
// Fine samples arrive in raster order on a grid of 2C+1 columns by 2R+1 rows, C and R
// being configuration registers 0 and 1 (zero acts as one), and one coarse sample
// leaves for every even fine row and column from 2 up, rounded towards minus
// infinity; tlast marks the final one of the frame. The block takes one sample per
// clock while the output queue has room: the only shared resource is the line store,
// read once when a sample is taken and written back the next cycle, with the written
// word forwarded when the next sample hits the same column. A result passes the
// read-modify-write stage register and the three-beat queue, which absorbs output
// stalls, before it is on m_axis. No clearing pass after reset.
`include "full_weighting_restriction_2d_macros.svh"
module full_weighting_restriction_2d (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_idx,
    input  logic [fwr2d_pkg::CFG_BITS-1:0] i_cfg_data,
    // fine samples
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // [15:0] sample
    input  logic                          s_axis_tuser,   // [0] frame_start
    // coarse samples
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [15:0] coarse_value
    output logic                          m_axis_tlast    // frame_last
);

    localparam int PB = fwr2d_pkg::POS_BITS;
    localparam logic [PB-1:0] MAX_W = PB'(fwr2d_pkg::MAX_FINE_WIDTH);

    logic [fwr2d_pkg::CFG_BITS-1:0] r_cc, r_cr;
    logic [PB-1:0] r_col, r_row, n_col, n_row;

    fwr2d_pkg::t_s1_ctrl   r_s1, n_s1;
    fwr2d_pkg::t_sample    r_cur;
    fwr2d_pkg::t_line_pair r_fwd_data;

    logic [fwr2d_pkg::CFG_BITS-1:0] cc_eff, cr_eff;
    logic [PB-1:0] width_raw, width, height;
    logic [PB-1:0] col_a, col;
    logic [PB:0]   row_a, row_b, col_inc, row_inc;
    logic [PB-1:0] row;
    logic          accept;

    fwr2d_pkg::t_line_pair rd_pair, pair, wr_pair;
    fwr2d_pkg::t_result    result;
    logic                  push;
    logic [fwr2d_pkg::CNT_BITS-1:0] q_count;

    // ---------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc <= fwr2d_pkg::CFG_BITS'(1);
            r_cr <= fwr2d_pkg::CFG_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fwr2d_pkg::CFG_IDX_COLS: r_cc <= i_cfg_data;
                fwr2d_pkg::CFG_IDX_ROWS: r_cr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- position of the incoming sample
    always_comb begin
        cc_eff    = (r_cc == '0) ? fwr2d_pkg::CFG_BITS'(1) : r_cc;
        cr_eff    = (r_cr == '0) ? fwr2d_pkg::CFG_BITS'(1) : r_cr;
        width_raw = {cc_eff, 1'b1};
        width     = (width_raw > MAX_W) ? MAX_W : width_raw;
        height    = {cr_eff, 1'b1};

        col_a = s_axis_tuser ? '0 : r_col;
        row_a = s_axis_tuser ? '0 : {1'b0, r_row};
        // geometry shrank under the counters: start a new row
        if (col_a >= width) begin
            col   = '0;
            row_b = row_a + 1'b1;
        end else begin
            col   = col_a;
            row_b = row_a;
        end
        row = (row_b >= {1'b0, height}) ? '0 : row_b[PB-1:0];

        col_inc = {1'b0, col} + 1'b1;
        row_inc = {1'b0, row} + 1'b1;
        if (col_inc >= {1'b0, width}) begin
            n_col = '0;
            n_row = (row_inc >= {1'b0, height}) ? '0 : row_inc[PB-1:0];
        end else begin
            n_col = col_inc[PB-1:0];
            n_row = row;
        end

        n_s1.valid = 1'b1;
        n_s1.emit  = (row >= PB'(2)) && (col >= PB'(2)) && !row[0] && !col[0];
        n_s1.last  = (row == height - 1'b1) && (col == width - 1'b1);
        n_s1.fwd   = r_s1.valid && (r_s1.col == col);
        n_s1.col   = col;
    end

    // room for the item in flight and this one once it reaches the queue
    assign s_axis_tready = ({1'b0, q_count} + {2'b00, push}) <= 3'(fwr2d_pkg::FIFO_DEPTH - 1);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_s1  <= '0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
                r_s1  <= n_s1;
            end else begin
                r_s1.valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur      <= s_axis_tdata;
            r_fwd_data <= wr_pair;
        end
    end

    // ---------------- line store read-modify-write
    fwr2d_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (col),
        .o_rd_data (rd_pair),
        .i_wr_en   (r_s1.valid),
        .i_wr_addr (r_s1.col),
        .i_wr_data (wr_pair)
    );

    // take the word still being written when the previous beat had this column
    assign pair        = r_s1.fwd ? r_fwd_data : rd_pair;
    assign wr_pair.mid = r_cur;
    assign wr_pair.up  = pair.mid;

    fwr2d_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (r_s1),
        .i_up     (pair.up),
        .i_mid    (pair.mid),
        .i_cur    (r_cur),
        .o_push   (push),
        .o_result (result)
    );

    fwr2d_pkg::t_result q_data;

    fwr2d_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_valid (m_axis_tvalid),
        .o_data  (q_data),
        .i_ready (m_axis_tready),
        .o_count (q_count)
    );

    assign m_axis_tdata = q_data.value;
    assign m_axis_tlast = q_data.last;

    `FWR2D_NEXT(a_s1_follows_accept, i_clk, i_rst_n, accept, r_s1.valid)
    `FWR2D_NEXT(a_s1_idle, i_clk, i_rst_n, !accept, !r_s1.valid)
    `FWR2D_NEXT(a_fwd_same_col, i_clk, i_rst_n, accept && r_s1.valid && (r_s1.col == col), r_s1.fwd)
    `FWR2D_IMPLY(a_last_emits, i_clk, i_rst_n, r_s1.valid && r_s1.last, r_s1.emit)

endmodule

FILE: bench/tb_full_weighting_restriction_2d.sv
`timescale 1ns / 1ps
// Self-checking bench for full_weighting_restriction_2d: raster frames of fine samples under
// random stalls on both streams, checked beat by beat against a line-store predictor.
// Depends on fwr2d_pkg and the block's RTL only.

module tb_full_weighting_restriction_2d;

    localparam int RANDOM_SAMPLES = 240;
    localparam int MAX_GAP        = 6;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WB             = fwr2d_pkg::POS_BITS + 1;

    // Predicts the coarse grid from accepted fine beats and holds the samples still due.
    class restrict_checker;
        logic [fwr2d_pkg::CFG_BITS-1:0] cols = fwr2d_pkg::CFG_BITS'(1);
        logic [fwr2d_pkg::CFG_BITS-1:0] rows = fwr2d_pkg::CFG_BITS'(1);
        fwr2d_pkg::t_sample             upper_row [fwr2d_pkg::MAX_FINE_WIDTH];
        fwr2d_pkg::t_sample             middle_row [fwr2d_pkg::MAX_FINE_WIDTH];
        int unsigned                    row_writes [fwr2d_pkg::MAX_FINE_WIDTH];
        fwr2d_pkg::t_sample             win [6];
        logic [fwr2d_pkg::POS_BITS-1:0] col_pos = '0;
        logic [fwr2d_pkg::POS_BITS-1:0] row_pos = '0;
        fwr2d_pkg::t_result             coarse_due [$];
        int unsigned                    coarse_seen = 0;
        int unsigned                    failures = 0;

        function new();
            foreach (win[i]) win[i] = '0;
            foreach (row_writes[i]) row_writes[i] = 0;
        endfunction

        function void configure(logic [0:0] idx, logic [fwr2d_pkg::CFG_BITS-1:0] data);
            if (idx == fwr2d_pkg::CFG_IDX_COLS) cols = data;
            else if (idx == fwr2d_pkg::CFG_IDX_ROWS) rows = data;
        endfunction

        function void take_fine(fwr2d_pkg::t_sample s, logic fs);
            logic [WB-1:0]                         width, height;
            fwr2d_pkg::t_sample                    up, mid;
            logic signed [fwr2d_pkg::SUM_BITS-1:0] acc, shifted;
            fwr2d_pkg::t_result                    r;
            width  = WB'(2 * ((cols == 0) ? 1 : int'(cols)) + 1);
            height = WB'(2 * ((rows == 0) ? 1 : int'(rows)) + 1);
            if (width > fwr2d_pkg::MAX_FINE_WIDTH) width = WB'(fwr2d_pkg::MAX_FINE_WIDTH);
            if (fs) begin
                col_pos = '0;
                row_pos = '0;
            end
            // geometry shrunk under a running frame: start a fresh row, wrap the row
            if (col_pos >= width) begin
                col_pos = '0;
                row_pos = row_pos + 1'b1;
            end
            if (row_pos >= height) row_pos = '0;
            up  = upper_row[col_pos];
            mid = middle_row[col_pos];
            upper_row[col_pos]  = mid;
            middle_row[col_pos] = s;
            row_writes[col_pos]++;
            if (row_pos >= 2 && col_pos >= 2 && !row_pos[0] && !col_pos[0]) begin
                acc = fwr2d_pkg::SUM_BITS'(win[0] + up + win[4] + s
                      + 2 * (win[1] + win[2] + mid + win[5]) + 4 * win[3]);
                shifted = acc >>> 4;
                r.value = shifted[fwr2d_pkg::SAMPLE_BITS-1:0];
                r.last  = (row_pos == height - 1) && (col_pos == width - 1);
                coarse_due.push_back(r);
            end
            win[0] = win[1];
            win[1] = up;
            win[2] = win[3];
            win[3] = mid;
            win[4] = win[5];
            win[5] = s;
            col_pos = col_pos + 1'b1;
            if (col_pos >= width) begin
                col_pos = '0;
                row_pos = row_pos + 1'b1;
                if (row_pos >= height) row_pos = '0;
            end
        endfunction

        function void match_coarse(fwr2d_pkg::t_sample got, logic got_last);
            fwr2d_pkg::t_result want;
            coarse_seen++;
            if (coarse_due.size() == 0) begin
                $error("coarse beat with nothing due: coarse_value %0d, frame_last %0b",
                       got, got_last);
                failures++;
            end else begin
                want = coarse_due.pop_front();
                if (got !== want.value) begin
                    $error("coarse_value: expected %0d, got %0d", want.value, got);
                    failures++;
                end
                if (got_last !== want.last) begin
                    $error("frame_last: expected %0b, got %0b", want.last, got_last);
                    failures++;
                end
            end
        endfunction

        // both line stores hold real data for every column below w
        function bit lines_ready(int w);
            for (int c = 0; c < w; c++)
                if (row_writes[c] < 2) return 1'b0;
            return 1'b1;
        endfunction

        function bit at_frame_head();
            return col_pos == 0 && row_pos == 0;
        endfunction
    endclass

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [0:0]                     i_cfg_idx     = fwr2d_pkg::CFG_IDX_COLS;
    logic [fwr2d_pkg::CFG_BITS-1:0] i_cfg_data    = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [15:0]                    s_axis_tdata  = '0;
    logic                           s_axis_tuser  = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [15:0]                    m_axis_tdata;
    logic                           m_axis_tlast;

    restrict_checker chk = new();
    bit src_quiet = 1'b0;
    bit snk_quiet = 1'b0;
    int fine_sent = 0;
    int settings  = 0;
    int cur_cc    = 1;
    int cur_cr    = 1;

    full_weighting_restriction_2d dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic fwr2d_pkg::t_sample pick_sample();
        unique case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return fwr2d_pkg::t_sample'(int'($urandom_range(0, 15)) - 8);
            default: return fwr2d_pkg::t_sample'($urandom);
        endcase
    endfunction

    function automatic int frame_samples();
        return (2 * cur_cc + 1) * (2 * cur_cr + 1);
    endfunction

    task automatic send_fine(input fwr2d_pkg::t_sample s, input logic fs);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        s_axis_tuser  <= fs;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        chk.take_fine(s, fs);
        fine_sent++;
    endtask

    // n random beats, frame_start on the first only if fs
    task automatic send_run(input int n, input logic fs);
        for (int i = 0; i < n; i++) send_fine(pick_sample(), (i == 0) ? fs : 1'b0);
    endtask

    task automatic finish_frame();
        do send_fine(pick_sample(), 1'b0); while (!chk.at_frame_head());
    endtask

    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (chk.coarse_due.size() != 0) @(posedge i_clk);
        // beats that make no result may still be in the pipe
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_geometry(input int cc, input int cr);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= fwr2d_pkg::CFG_IDX_COLS;
        i_cfg_data <= cc[fwr2d_pkg::CFG_BITS-1:0];
        @(posedge i_clk);
        chk.configure(fwr2d_pkg::CFG_IDX_COLS, cc[fwr2d_pkg::CFG_BITS-1:0]);
        i_cfg_idx  <= fwr2d_pkg::CFG_IDX_ROWS;
        i_cfg_data <= cr[fwr2d_pkg::CFG_BITS-1:0];
        @(posedge i_clk);
        chk.configure(fwr2d_pkg::CFG_IDX_ROWS, cr[fwr2d_pkg::CFG_BITS-1:0]);
        i_cfg_we <= 1'b0;
        cur_cc = (cc == 0) ? 1 : cc;
        cur_cr = (cr == 0) ? 1 : cr;
        settings++;
    endtask

    initial begin : coarse_sink
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = snk_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            chk.match_coarse(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin : stimulus
        int   cc, cr, nframes, kind, base;
        logic mid, carry;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry 3x3: full-scale frames, the second entered by wrap alone
        for (int i = 0; i < 9; i++) send_fine(16'sh7fff, i == 0);
        for (int i = 0; i < 9; i++) send_fine(16'sh8000, 1'b0);
        // abandon a frame, restart it; a lone -1 at the centre must floor to -1
        send_run(2, 1'b0);
        for (int i = 0; i < 9; i++)
            send_fine((i == 4) ? fwr2d_pkg::t_sample'(-1) : fwr2d_pkg::t_sample'(0), i == 0);
        drain_and_settle();

        set_geometry(0, 0);
        send_run(9, 1'b1);
        send_run(9, 1'b0);
        drain_and_settle();
        // widest and tallest grids, the opening rows only
        set_geometry(511, 1);
        send_run(40, 1'b1);
        drain_and_settle();
        set_geometry(1, 511);
        send_run(60, 1'b1);
        drain_and_settle();
        // shrink under a running frame: column and row both fall outside the new grid
        set_geometry(3, 3);
        send_run(frame_samples(), 1'b1);
        send_run(41, 1'b1);
        drain_and_settle();
        set_geometry(1, 1);
        finish_frame();
        drain_and_settle();

        base = fine_sent;
        while (fine_sent - base < RANDOM_SAMPLES) begin
            mid   = !chk.at_frame_head();
            cc    = mid ? $urandom_range(1, cur_cc) : $urandom_range(0, 6);
            cr    = $urandom_range(0, 4);
            carry = mid && chk.lines_ready(2 * cc + 1) && ($urandom_range(0, 1) == 1);
            src_quiet = ($urandom_range(0, 3) == 0);
            snk_quiet = ($urandom_range(0, 3) == 0);
            set_geometry(cc, cr);
            if (carry) finish_frame();
            nframes = $urandom_range(1, 3);
            repeat (nframes) begin
                kind = $urandom_range(0, 9);
                if (kind == 0)
                    send_run($urandom_range(1, frame_samples() - 1), 1'b1);
                else
                    send_run(frame_samples(), !(kind < 3 && chk.at_frame_head()));
            end
            // leave some phases mid-frame so the next one resizes under it
            if ($urandom_range(0, 2) == 0)
                send_run($urandom_range(1, frame_samples() - 1), 1'b1);
            drain_and_settle();
        end

        $display("Sent %0d fine samples over %0d geometry settings, checked %0d coarse samples.",
                 fine_sent, settings, chk.coarse_seen);
        $display("Ran zero-size grids, the start of the widest and tallest, wrapped, cut and resized frames.");
        if (chk.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/fwr2d_pkg.sv
sv/fwr2d_line_mem.sv
sv/fwr2d_window.sv
sv/fwr2d_out_fifo.sv
sv/full_weighting_restriction_2d.sv
bench/tb_full_weighting_restriction_2d.sv
